@@ design/pno_pkg.sv @@
// ----------------------------------------------------------------------------
// pno_pkg: shared types and constants for the octave gradient noise block
// Permutation table, command and pipeline tag types, register indexes.
// ----------------------------------------------------------------------------
package pno_pkg;

  // Fixed lattice permutation of 0..255
  localparam logic [7:0] PERM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
    8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
    8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
    8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
    8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
    8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
    8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
    8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
    8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
    8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
    8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
    8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
    8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
    8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
    8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
    8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
    8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
    8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
    8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
    8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
    8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
    8'd215,8'd61,8'd156,8'd180
  };

  // Command queue depth between front and back
  localparam int QDEPTH = 4;
  localparam int QCW    = $clog2(QDEPTH + 1);
  localparam int QPW    = $clog2(QDEPTH);

  // Amplitude of 1.0 in Q.16
  localparam logic [16:0] AMP_ONE = 17'd65536;

  // Register indexes
  localparam logic [1:0] REG_OCTAVES = 2'd0;
  localparam logic [1:0] REG_PERSIST = 2'd1;
  localparam logic [1:0] REG_FREQ    = 2'd2;

  // Queued command: low 40 bits of each scaled base coordinate (Q.32)
  typedef struct packed {
    logic [39:0] bx;
    logic [39:0] by;
    logic [39:0] bz;
    logic [3:0]  noct;
    logic [16:0] pers;
  } cmd_t;

  // Tag traveling with each octave through the evaluator
  typedef struct packed {
    logic        vld;
    logic        first;
    logic        last;
    logic        zero;
    logic [16:0] amp;
  } tag_t;

  // Queue status
  typedef struct packed {
    logic [QCW-1:0] cnt;
    logic           full;
  } fstat_t;

endpackage

@@ design/pno_front.sv @@
// ----------------------------------------------------------------------------
// pno_front: command intake
// Accepts points, scales them by the base frequency and queues the commands.
// ----------------------------------------------------------------------------
module pno_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [31:0]          in_coord_x,
  input  logic [31:0]          in_coord_y,
  input  logic [31:0]          in_coord_z,
  input  logic [3:0]           octave_count,
  input  logic [16:0]          persistence,
  input  logic [23:0]          base_frequency,
  input  logic                 pop,
  output logic                 head_vld,
  output pno_pkg::cmd_t        head,
  output pno_pkg::fstat_t      stat
);
  import pno_pkg::*;

  logic               p_v_r;
  cmd_t               p_cmd_r;
  cmd_t               q_r [QDEPTH];
  logic [QCW-1:0]     cnt_r;
  logic [QPW-1:0]     wp_r, rp_r;
  logic               acc;
  logic signed [56:0] px, py, pz;
  logic [QCW:0]       occ;

  // Room for the staged command plus one more
  assign occ  = {1'b0, cnt_r} + {{QCW{1'b0}}, p_v_r};
  assign busy = (occ >= (QCW+1)'(QDEPTH));
  assign acc  = start && !busy;

  // Scale by base frequency
  assign px = $signed(in_coord_x) * $signed({1'b0, base_frequency});
  assign py = $signed(in_coord_y) * $signed({1'b0, base_frequency});
  assign pz = $signed(in_coord_z) * $signed({1'b0, base_frequency});

  // Staging register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else begin
      p_v_r <= acc;
    end
    if (acc) begin
      p_cmd_r.bx   <= px[39:0];
      p_cmd_r.by   <= py[39:0];
      p_cmd_r.bz   <= pz[39:0];
      p_cmd_r.noct <= octave_count;
      p_cmd_r.pers <= (persistence > AMP_ONE) ? AMP_ONE : persistence;
    end
  end

  // Command queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= '0;
      rp_r  <= '0;
    end else begin
      if (p_v_r) wp_r <= wp_r + 1'b1;
      if (pop)   rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + QCW'(p_v_r) - QCW'(pop);
    end
    if (p_v_r) q_r[wp_r] <= p_cmd_r;
  end

  assign head_vld  = (cnt_r != '0);
  assign head      = q_r[rp_r];
  assign stat.cnt  = cnt_r;
  assign stat.full = (cnt_r == QCW'(QDEPTH));

endmodule

@@ design/pno_octave.sv @@
// ----------------------------------------------------------------------------
// pno_octave: pipelined single-octave noise evaluator
// Lattice hash, fade, gradients, trilinear blend and amplitude weighting.
// ----------------------------------------------------------------------------
module pno_octave #(
  parameter int F  = 16,
  parameter int KW = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pno_pkg::tag_t        in_tag,
  input  logic [39:0]          bx,
  input  logic [39:0]          by,
  input  logic [39:0]          bz,
  input  logic [KW-1:0]        k,
  output pno_pkg::tag_t        out_tag,
  output logic signed [F+3:0]  term
);
  import pno_pkg::*;

  localparam int GW = F + 3;
  localparam int TW = F + 4;
  localparam logic signed [F:0] ONE_F = (F+1)'(1) << F;
  // 1.0 in Q1.F as an unsigned value, upper clamp of the fade
  localparam logic [F:0] ONE_U = (F+1)'(1) << F;

  // Fractional product, floored to Q0.F
  function automatic logic [F-1:0] mulf(input logic [F-1:0] a, input logic [F-1:0] b);
    logic [2*F-1:0] p;
    p = a * b;
    return p[2*F-1:F];
  endfunction

  // 10t3 - 15t4 + 6t5 clamped to [0, 1]
  function automatic logic [F:0] fadef(input logic [F-1:0] t3, input logic [F-1:0] t4,
                                       input logic [F-1:0] t5);
    logic signed [F+6:0] s;
    s = $signed({7'd0, t3}) * (F+7)'(10) - $signed({7'd0, t4}) * (F+7)'(15)
      + $signed({7'd0, t5}) * (F+7)'(6);
    if (s < 0) return '0;
    if (s > $signed({6'd0, ONE_U})) return ONE_U;
    return s[F:0];
  endfunction

  // Edge gradient dot product
  function automatic logic signed [GW-1:0] gradf(input logic [3:0] h,
    input logic signed [F:0] x, input logic signed [F:0] y, input logic signed [F:0] z);
    logic signed [GW-1:0] a, b;
    a = (h < 4'd8) ? GW'(x) : GW'(y);
    if (h < 4'd4)                    b = GW'(y);
    else if (h == 4'd12 || h == 4'd14) b = GW'(x);
    else                             b = GW'(z);
    if (h[0]) a = -a;
    if (h[1]) b = -b;
    return a + b;
  endfunction

  // a + floor((b-a)*f / 2^F)
  function automatic logic signed [GW-1:0] lerpf(input logic signed [GW-1:0] a,
    input logic signed [GW-1:0] b, input logic [F:0] f);
    logic signed [GW:0]       d;
    logic signed [GW+F+1:0]   p;
    d = $signed({b[GW-1], b}) - $signed({a[GW-1], a});
    p = d * $signed({1'b0, f});
    p = p >>> F;
    return a + p[GW-1:0];
  endfunction

  tag_t tg_r [10];

  logic [39:0]  sx, sy, sz;
  logic [7:0]   c1_r [3];
  logic [F-1:0] f1_r [3], f2_r [3], f3_r [3], f4_r [3];
  logic [F-1:0] t2_r [3], t3_r [3], t3b_r [3], t3c_r [3], t4_r [3], t4b_r [3], t5_r [3];
  logic [7:0]   ra2_r, rb2_r, cy2_r, cz2_r;
  logic [7:0]   pa3_r, pa13_r, pb3_r, pb13_r, cz3_r;
  logic [3:0]   h4_r [8];
  logic signed [GW-1:0] g5_r [8], g6_r [8], l7_r [4], m8_r [2], n9_r;
  logic [F:0]   u6_r, v6_r, w6_r, v7_r, w7_r, w8_r;
  logic [7:0]   aa, ab, ba, bb;
  logic signed [GW+17:0] wp;

  // Scaled coordinate bits for this octave
  assign sx = bx << k;
  assign sy = by << k;
  assign sz = bz << k;
  assign aa = pa3_r + cz3_r;
  assign ab = pa13_r + cz3_r;
  assign ba = pb3_r + cz3_r;
  assign bb = pb13_r + cz3_r;
  assign wp = n9_r * $signed({1'b0, tg_r[8].amp});

  // Tag pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < 10; s++) tg_r[s].vld <= 1'b0;
    end else begin
      tg_r[0].vld <= in_tag.vld;
      for (int s = 1; s < 10; s++) tg_r[s].vld <= tg_r[s-1].vld;
    end
    {tg_r[0].first, tg_r[0].last, tg_r[0].zero, tg_r[0].amp} <=
      {in_tag.first, in_tag.last, in_tag.zero, in_tag.amp};
    for (int s = 1; s < 10; s++)
      {tg_r[s].first, tg_r[s].last, tg_r[s].zero, tg_r[s].amp} <=
        {tg_r[s-1].first, tg_r[s-1].last, tg_r[s-1].zero, tg_r[s-1].amp};
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    // cell and fraction
    c1_r[0] <= sx[39:32]; c1_r[1] <= sy[39:32]; c1_r[2] <= sz[39:32];
    f1_r[0] <= sx[31:32-F]; f1_r[1] <= sy[31:32-F]; f1_r[2] <= sz[31:32-F];
    // first hash level, t^2
    ra2_r <= PERM[c1_r[0]];
    rb2_r <= PERM[c1_r[0] + 8'd1];
    cy2_r <= c1_r[1];
    cz2_r <= c1_r[2];
    for (int i = 0; i < 3; i++) begin
      f2_r[i] <= f1_r[i];
      t2_r[i] <= mulf(f1_r[i], f1_r[i]);
    end
    // second hash level, t^3
    pa3_r  <= PERM[ra2_r + cy2_r];
    pa13_r <= PERM[ra2_r + cy2_r + 8'd1];
    pb3_r  <= PERM[rb2_r + cy2_r];
    pb13_r <= PERM[rb2_r + cy2_r + 8'd1];
    cz3_r  <= cz2_r;
    for (int i = 0; i < 3; i++) begin
      f3_r[i] <= f2_r[i];
      t3_r[i] <= mulf(t2_r[i], f2_r[i]);
    end
    // corner hashes, t^4
    h4_r[0] <= PERM[aa][3:0];        h4_r[1] <= PERM[ba][3:0];
    h4_r[2] <= PERM[ab][3:0];        h4_r[3] <= PERM[bb][3:0];
    h4_r[4] <= PERM[aa + 8'd1][3:0]; h4_r[5] <= PERM[ba + 8'd1][3:0];
    h4_r[6] <= PERM[ab + 8'd1][3:0]; h4_r[7] <= PERM[bb + 8'd1][3:0];
    for (int i = 0; i < 3; i++) begin
      f4_r[i]  <= f3_r[i];
      t3b_r[i] <= t3_r[i];
      t4_r[i]  <= mulf(t3_r[i], f3_r[i]);
    end
    // gradients, t^5; corner index bits select x, y, z offsets
    for (int c = 0; c < 8; c++)
      g5_r[c] <= gradf(h4_r[c],
        c[0] ? $signed({1'b0, f4_r[0]}) - ONE_F : $signed({1'b0, f4_r[0]}),
        c[1] ? $signed({1'b0, f4_r[1]}) - ONE_F : $signed({1'b0, f4_r[1]}),
        c[2] ? $signed({1'b0, f4_r[2]}) - ONE_F : $signed({1'b0, f4_r[2]}));
    for (int i = 0; i < 3; i++) begin
      t3c_r[i] <= t3b_r[i];
      t4b_r[i] <= t4_r[i];
      t5_r[i]  <= mulf(t4_r[i], f4_r[i]);
    end
    // fade curves
    u6_r <= fadef(t3c_r[0], t4b_r[0], t5_r[0]);
    v6_r <= fadef(t3c_r[1], t4b_r[1], t5_r[1]);
    w6_r <= fadef(t3c_r[2], t4b_r[2], t5_r[2]);
    for (int c = 0; c < 8; c++) g6_r[c] <= g5_r[c];
    // blend along x
    for (int j = 0; j < 4; j++) l7_r[j] <= lerpf(g6_r[2*j], g6_r[2*j+1], u6_r);
    v7_r <= v6_r;
    w7_r <= w6_r;
    // blend along y
    m8_r[0] <= lerpf(l7_r[0], l7_r[1], v7_r);
    m8_r[1] <= lerpf(l7_r[2], l7_r[3], v7_r);
    w8_r    <= w7_r;
    // blend along z
    n9_r <= lerpf(m8_r[0], m8_r[1], w8_r);
    // amplitude weighting
    term <= tg_r[8].zero ? '0 : TW'(wp >>> 16);
  end

  assign out_tag = tg_r[9];

endmodule

@@ design/pno_back.sv @@
// ----------------------------------------------------------------------------
// pno_back: octave sequencer and accumulator
// Issues one octave per cycle into the evaluator and sums the weighted terms.
// ----------------------------------------------------------------------------
module pno_back #(
  parameter int MAX_OCTAVES = 8,
  parameter int FRAC_BITS   = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_vld,
  input  pno_pkg::cmd_t        head,
  output logic                 pop,
  output logic                 out_valid,
  output logic signed [20:0]   out_noise_value
);
  import pno_pkg::*;

  localparam int KW    = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
  localparam int TW    = FRAC_BITS + 4;
  localparam int AW    = TW + $clog2(MAX_OCTAVES) + 1;
  localparam int SH_R  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SH_L  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int RW    = AW + 9;
  localparam logic signed [RW-1:0] OMAX = RW'(1048575);
  localparam logic signed [RW-1:0] OMIN = -RW'(1048576);

  logic          act_r;
  cmd_t          cmd_r;
  logic [KW-1:0] k_r;
  logic [16:0]   amp_r;
  logic [4:0]    ne;
  logic          zero, last;
  logic [33:0]   ap;
  tag_t          it, ot;
  logic signed [TW-1:0] term;
  logic signed [AW-1:0] acc_r, sum;
  logic signed [RW-1:0] rx;

  // Octave count limit
  assign ne   = ({1'b0, cmd_r.noct} > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES) : {1'b0, cmd_r.noct};
  assign zero = (ne == 5'd0);
  assign last = zero || (5'(k_r) == ne - 5'd1);
  assign pop  = head_vld && (!act_r || last);
  assign ap   = amp_r * cmd_r.pers;

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else if (pop) begin
      act_r <= 1'b1;
    end else if (act_r && last) begin
      act_r <= 1'b0;
    end
    if (pop) begin
      cmd_r <= head;
      k_r   <= '0;
      amp_r <= AMP_ONE;
    end else if (act_r) begin
      k_r   <= k_r + 1'b1;
      amp_r <= ap[32:16];
    end
  end

  assign it.vld   = act_r;
  assign it.first = (k_r == '0);
  assign it.last  = last;
  assign it.zero  = zero;
  assign it.amp   = amp_r;

  pno_octave #(.F(FRAC_BITS), .KW(KW)) u_oct (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_tag  (it),
    .bx      (cmd_r.bx),
    .by      (cmd_r.by),
    .bz      (cmd_r.bz),
    .k       (k_r),
    .out_tag (ot),
    .term    (term)
  );

  // Accumulate, convert to Q4.16 and saturate
  assign sum = (ot.first ? AW'(0) : acc_r) + AW'(term);
  assign rx  = (RW'(sum) <<< SH_L) >>> SH_R;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= ot.vld && ot.last;
    end
    if (ot.vld) acc_r <= sum;
    if (rx > OMAX)      out_noise_value <= OMAX[20:0];
    else if (rx < OMIN) out_noise_value <= OMIN[20:0];
    else                out_noise_value <= rx[20:0];
  end

endmodule

@@ design/perlin_noise_3d_octaves.sv @@
// ----------------------------------------------------------------------------
// perlin_noise_3d_octaves: fractal 3D gradient noise, fixed point
// Top level with APB register file, command front end and octave back end.
// ----------------------------------------------------------------------------
// A point is taken when start is high and busy is low; its Q4.16 noise sum
// appears on out_noise_value for one cycle with out_valid, in order, and the
// receiver cannot hold it off. The back end issues one octave per clock into
// a single pipelined evaluator; octave_count is capped at MAX_OCTAVES, and a
// point with octave_count zero still passes through and yields zero. Each
// point goes through the staging register, queue, sequencer and evaluator.
// A four-entry command queue lets new points enter while older ones run.
module perlin_noise_3d_octaves #(
  parameter int MAX_OCTAVES = 8,
  parameter int FRAC_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic signed [31:0]  in_coord_x,
  input  logic signed [31:0]  in_coord_y,
  input  logic signed [31:0]  in_coord_z,
  output logic                out_valid,
  output logic signed [20:0]  out_noise_value,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import pno_pkg::*;

  logic [3:0]  oct_r;
  logic [16:0] pers_r;
  logic [23:0] freq_r;
  logic        wr;
  logic        pop, head_vld;
  cmd_t        head;
  fstat_t      fst;

  // Register file
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oct_r  <= 4'd1;
      pers_r <= 17'd32768;
      freq_r <= 24'd65536;
    end else if (wr) begin
      case (paddr[3:2])
        REG_OCTAVES: oct_r  <= pwdata[3:0];
        REG_PERSIST: pers_r <= pwdata[16:0];
        REG_FREQ:    freq_r <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_OCTAVES: prdata = {28'd0, oct_r};
      REG_PERSIST: prdata = {15'd0, pers_r};
      REG_FREQ:    prdata = {8'd0, freq_r};
      default:     prdata = '0;
    endcase
  end

  pno_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .in_coord_z     (in_coord_z),
    .octave_count   (oct_r),
    .persistence    (pers_r),
    .base_frequency (freq_r),
    .pop            (pop),
    .head_vld       (head_vld),
    .head           (head),
    .stat           (fst)
  );

  pno_back #(.MAX_OCTAVES(MAX_OCTAVES), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_vld        (head_vld),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_noise_value (out_noise_value)
  );

  // Queue never overfills
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fst.cnt <= QCW'(QDEPTH)) else $error("command queue overflow");

  // A full queue holds off new transactions
  a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
    fst.full |-> busy) else $error("accepting while queue full");

  // No result can come straight out of reset
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(rst_n)) else $error("result right after reset");

endmodule
